// ----- rtl/rds_pkg.sv -----
// Shared types, constants and saturation helpers for the reaction-diffusion stencil step.
package rds_pkg;

   localparam int COLS_DEF  = 64;
   localparam int ROWS_DEF  = 64;
   localparam int FRAC_DEF  = 16;

   localparam int DATA_W    = 32;
   localparam int WIDE_W    = 64;
   localparam int MAG_W     = 60;
   localparam int HALF_W    = 30;
   localparam int ACC_W     = 120;
   localparam int CSR_W     = 32;
   localparam int IDX_W     = 3;
   localparam int POS_W     = 6;

   localparam logic signed [WIDE_W-1:0] WIDE_MAX = 64'sh0FFF_FFFF_FFFF_FFFF;
   localparam logic signed [WIDE_W-1:0] OUT_MAX  = 64'sd2147483647;
   localparam logic signed [WIDE_W-1:0] OUT_MIN  = -64'sd2147483648;

   typedef enum logic [IDX_W-1:0] {
      CSR_U_DIFF = 3'd0,
      CSR_V_DIFF = 3'd1,
      CSR_FEED_A = 3'd2,
      CSR_RATE_B = 3'd3,
      CSR_STEP   = 3'd4,
      CSR_ISS    = 3'd5,
      CSR_MODE   = 3'd6,
      CSR_BMASK  = 3'd7
   } csr_index_type;

   // products in issue order
   typedef enum logic [3:0] {
      OP_LAPU = 4'd0,
      OP_LAPV = 4'd1,
      OP_UU   = 4'd2,
      OP_UUV  = 4'd3,
      OP_T1   = 4'd4,
      OP_T2   = 4'd5,
      OP_T3   = 4'd6,
      OP_T4   = 4'd7,
      OP_EU   = 4'd8,
      OP_EV   = 4'd9
   } op_type;

   typedef struct packed {
      logic   take;
      logic   shift;
      logic   mul_start;
      logic   combine;
      logic   load_rsp;
      op_type op;
   } ctrl_cmd_type;

   typedef struct packed {
      logic interior;
      logic mul_done;
      logic euler;
      logic rsp_full;
   } dp_status_type;

   typedef struct packed {
      logic [DATA_W-1:0] u_new;
      logic [DATA_W-1:0] u_old;
      logic [DATA_W-1:0] v_new;
      logic [DATA_W-1:0] v_old;
   } lbuf_word_type;

   function automatic logic signed [WIDE_W-1:0] sat_wide(input logic signed [WIDE_W-1:0] x);
      logic signed [WIDE_W-1:0] r;
      r = x;
      if (x > WIDE_MAX) r = WIDE_MAX;
      if (x < -WIDE_MAX) r = -WIDE_MAX;
      return r;
   endfunction

   function automatic logic signed [DATA_W-1:0] sat_out(input logic signed [WIDE_W-1:0] x);
      logic signed [WIDE_W-1:0] r;
      r = x;
      if (x > OUT_MAX) r = OUT_MAX;
      if (x < OUT_MIN) r = OUT_MIN;
      return r[DATA_W-1:0];
   endfunction

endpackage

// ----- rtl/rds_if.sv -----
// Request and response stream interfaces.
interface rds_req_if;
   logic                     valid;
   logic                     ready;
   logic signed [31:0]       u_value;
   logic signed [31:0]       v_value;
   logic                     frame_start;
   modport source (output valid, u_value, v_value, frame_start, input ready);
   modport sink   (input valid, u_value, v_value, frame_start, output ready);
endinterface

interface rds_rsp_if;
   logic                     valid;
   logic                     ready;
   logic signed [31:0]       u_out;
   logic signed [31:0]       v_out;
   logic [5:0]               out_row;
   logic [5:0]               out_col;
   logic                     frame_last;
   modport source (output valid, u_out, v_out, out_row, out_col, frame_last, input ready);
   modport sink   (input valid, u_out, v_out, out_row, out_col, frame_last, output ready);
endinterface

// ----- rtl/rds_mul.sv -----
// Shared fixed-point multiplier: floor(a*b/2^FRAC_BITS), saturated, four 30x30 partial products.
module rds_mul #(
   parameter int FRAC_BITS = rds_pkg::FRAC_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [rds_pkg::WIDE_W-1:0]   a,
   input  logic signed [rds_pkg::WIDE_W-1:0]   b,
   output logic                                done,
   output logic signed [rds_pkg::WIDE_W-1:0]   result
);

   localparam int W  = rds_pkg::WIDE_W;
   localparam int MW = rds_pkg::MAG_W;
   localparam int HW = rds_pkg::HALF_W;
   localparam int AW = rds_pkg::ACC_W;
   localparam logic [AW-1:0] REM_MASK = (AW'(1) << FRAC_BITS) - AW'(1);

   logic [MW-1:0]   ma_ff, mb_ff;
   logic            neg_ff;
   logic [AW-1:0]   acc_ff, acc_in;
   logic [2:0]      step_ff, step_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic signed [W-1:0] result_ff, result_in;

   logic [W-1:0]    ua, ub, abs_a, abs_b;
   logic [HW-1:0]   pa, pb;
   logic [2*HW-1:0] pp;
   logic [AW-1:0]   pp_sh, q;
   logic            rem, big;
   logic [MW:0]     nr;

   assign ua    = a;
   assign ub    = b;
   assign abs_a = a[W-1] ? (~ua + W'(1)) : ua;
   assign abs_b = b[W-1] ? (~ub + W'(1)) : ub;

   assign pa = step_ff[1] ? ma_ff[MW-1:HW] : ma_ff[HW-1:0];
   assign pb = step_ff[0] ? mb_ff[MW-1:HW] : mb_ff[HW-1:0];
   assign pp = pa * pb;

   always_comb begin
      case (step_ff)
         3'd0:    pp_sh = {{(AW-2*HW){1'b0}}, pp};
         3'd3:    pp_sh = {pp, {(AW-2*HW){1'b0}}};
         default: pp_sh = {{(AW-3*HW){1'b0}}, pp, {HW{1'b0}}};
      endcase
   end

   assign q   = acc_ff >> FRAC_BITS;
   assign rem = |(acc_ff & REM_MASK);
   assign big = |q[AW-1:MW];
   assign nr  = {1'b0, q[MW-1:0]} + (MW+1)'(rem);

   always_comb begin
      acc_in    = acc_ff;
      step_in   = step_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      result_in = result_ff;
      if (start) begin
         acc_in  = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (step_ff == 3'd4) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (big) begin
               result_in = neg_ff ? -rds_pkg::WIDE_MAX : rds_pkg::WIDE_MAX;
            end else if (neg_ff) begin
               result_in = nr[MW] ? -rds_pkg::WIDE_MAX : -$signed({3'b000, nr});
            end else begin
               result_in = $signed({4'b0000, q[MW-1:0]});
            end
         end else begin
            acc_in  = acc_ff + pp_sh;
            step_in = step_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      acc_ff    <= acc_in;
      result_ff <= result_in;
      if (start) begin
         ma_ff  <= abs_a[MW-1:0];
         mb_ff  <= abs_b[MW-1:0];
         neg_ff <= a[W-1] ^ b[W-1];
      end
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

// ----- rtl/rds_dp.sv -----
// Datapath: settings, line store, 3x3 windows, product registers and result register.
module rds_dp #(
   parameter int COLS      = rds_pkg::COLS_DEF,
   parameter int ROWS      = rds_pkg::ROWS_DEF,
   parameter int FRAC_BITS = rds_pkg::FRAC_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  rds_pkg::ctrl_cmd_type                cmd,
   output rds_pkg::dp_status_type               status,
   input  logic                                 csr_we,
   input  rds_pkg::csr_index_type               csr_index,
   input  logic [rds_pkg::CSR_W-1:0]            csr_wdata,
   input  logic signed [rds_pkg::DATA_W-1:0]    in_u,
   input  logic signed [rds_pkg::DATA_W-1:0]    in_v,
   input  logic                                 in_frame_start,
   input  logic                                 out_ready,
   output logic                                 out_valid,
   output logic signed [rds_pkg::DATA_W-1:0]    out_u,
   output logic signed [rds_pkg::DATA_W-1:0]    out_v,
   output logic [rds_pkg::POS_W-1:0]            out_row,
   output logic [rds_pkg::POS_W-1:0]            out_col,
   output logic                                 out_last
);

   localparam int DW       = rds_pkg::DATA_W;
   localparam int W        = rds_pkg::WIDE_W;
   localparam int PAD_COLS = COLS + 2;
   localparam int PAD_ROWS = ROWS + 2;
   localparam int CW       = $clog2(PAD_COLS);
   localparam int RW       = $clog2(PAD_ROWS);
   localparam int CX       = (CW > rds_pkg::POS_W) ? CW : rds_pkg::POS_W;
   localparam int RX       = (RW > rds_pkg::POS_W) ? RW : rds_pkg::POS_W;
   localparam logic signed [W-1:0] Q_ONE = 64'sd1 <<< FRAC_BITS;

   // settings
   logic [30:0]          du_ff, dv_ff, dt_ff, iss_ff;
   logic signed [DW-1:0] fa_ff, rb_ff;
   logic                 mode_ff;
   logic [3:0]           mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         du_ff   <= 31'd65536;
         dv_ff   <= 31'd65536;
         fa_ff   <= 32'sd65536;
         rb_ff   <= 32'sd196608;
         dt_ff   <= 31'd655;
         iss_ff  <= 31'd65536;
         mode_ff <= 1'b0;
         mask_ff <= 4'd0;
      end else if (csr_we) begin
         unique case (csr_index)
            rds_pkg::CSR_U_DIFF: du_ff   <= csr_wdata[30:0];
            rds_pkg::CSR_V_DIFF: dv_ff   <= csr_wdata[30:0];
            rds_pkg::CSR_FEED_A: fa_ff   <= csr_wdata;
            rds_pkg::CSR_RATE_B: rb_ff   <= csr_wdata;
            rds_pkg::CSR_STEP:   dt_ff   <= csr_wdata[30:0];
            rds_pkg::CSR_ISS:    iss_ff  <= csr_wdata[30:0];
            rds_pkg::CSR_MODE:   mode_ff <= csr_wdata[0];
            rds_pkg::CSR_BMASK:  mask_ff <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // raster position
   logic [CW-1:0] col_ff, col_in, cur_c_ff, c_now;
   logic [RW-1:0] row_ff, row_in, cur_r_ff, r_now;

   assign c_now = in_frame_start ? '0 : col_ff;
   assign r_now = in_frame_start ? '0 : row_ff;

   always_comb begin
      col_in = c_now + CW'(1);
      row_in = r_now;
      if (c_now == CW'(PAD_COLS - 1)) begin
         col_in = '0;
         row_in = (r_now == RW'(PAD_ROWS - 1)) ? '0 : r_now + RW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (cmd.take) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
      if (cmd.take) begin
         cur_c_ff <= c_now;
         cur_r_ff <= r_now;
      end
   end

   // line store: per column, the two previous rows of both fields
   rds_pkg::lbuf_word_type lbuf [PAD_COLS];
   rds_pkg::lbuf_word_type rd_ff;
   logic signed [DW-1:0]   in_u_ff, in_v_ff;

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         rd_ff   <= lbuf[c_now];
         in_u_ff <= in_u;
         in_v_ff <= in_v;
      end
      if (cmd.shift) begin
         lbuf[cur_c_ff] <= '{u_new: in_u_ff, u_old: rd_ff.u_new,
                             v_new: in_v_ff, v_old: rd_ff.v_new};
      end
   end

   // 3x3 windows, column 2 is the newest
   logic signed [DW-1:0] wu_ff [9];
   logic signed [DW-1:0] wv_ff [9];

   always_ff @(posedge clock) begin
      if (cmd.shift) begin
         for (int k = 0; k < 3; k++) begin
            wu_ff[3*k]   <= wu_ff[3*k+1];
            wu_ff[3*k+1] <= wu_ff[3*k+2];
            wv_ff[3*k]   <= wv_ff[3*k+1];
            wv_ff[3*k+1] <= wv_ff[3*k+2];
         end
         wu_ff[2] <= rd_ff.u_old;
         wu_ff[5] <= rd_ff.u_new;
         wu_ff[8] <= in_u_ff;
         wv_ff[2] <= rd_ff.v_old;
         wv_ff[5] <= rd_ff.v_new;
         wv_ff[8] <= in_v_ff;
      end
   end

   logic signed [35:0] sum_u, sum_v;
   assign sum_u = 36'(wu_ff[1]) + 36'(wu_ff[7]) + 36'(wu_ff[3]) + 36'(wu_ff[5])
                  - (36'(wu_ff[4]) <<< 2);
   assign sum_v = 36'(wv_ff[1]) + 36'(wv_ff[7]) + 36'(wv_ff[3]) + 36'(wv_ff[5])
                  - (36'(wv_ff[4]) <<< 2);

   logic signed [W-1:0] uc, vc;
   assign uc = W'(wu_ff[4]);
   assign vc = W'(wv_ff[4]);

   // products
   logic signed [W-1:0] lapu_ff, lapv_ff, uu_ff, uuv_ff, t1_ff, t2_ff, t3_ff, t4_ff;
   logic signed [W-1:0] rhsu_ff, rhsv_ff, eu_ff, ev_ff;
   logic signed [W-1:0] op_a, op_b, mul_res;
   logic                mul_done;

   always_comb begin
      case (cmd.op)
         rds_pkg::OP_LAPU: begin op_a = W'(sum_u);       op_b = W'(iss_ff); end
         rds_pkg::OP_LAPV: begin op_a = W'(sum_v);       op_b = W'(iss_ff); end
         rds_pkg::OP_UU:   begin op_a = uc;              op_b = uc;         end
         rds_pkg::OP_UUV:  begin op_a = uu_ff;           op_b = vc;         end
         rds_pkg::OP_T1:   begin op_a = W'(du_ff);       op_b = lapu_ff;    end
         rds_pkg::OP_T2:   begin op_a = W'(rb_ff) + Q_ONE; op_b = uc;       end
         rds_pkg::OP_T3:   begin op_a = W'(dv_ff);       op_b = lapv_ff;    end
         rds_pkg::OP_T4:   begin op_a = W'(rb_ff);       op_b = uc;         end
         rds_pkg::OP_EU:   begin op_a = W'(dt_ff);       op_b = rhsu_ff;    end
         rds_pkg::OP_EV:   begin op_a = W'(dt_ff);       op_b = rhsv_ff;    end
         default:          begin op_a = '0;              op_b = '0;         end
      endcase
   end

   rds_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.mul_start),
      .a      (op_a),
      .b      (op_b),
      .done   (mul_done),
      .result (mul_res)
   );

   always_ff @(posedge clock) begin
      if (mul_done) begin
         case (cmd.op)
            rds_pkg::OP_LAPU: lapu_ff <= mul_res;
            rds_pkg::OP_LAPV: lapv_ff <= mul_res;
            rds_pkg::OP_UU:   uu_ff   <= mul_res;
            rds_pkg::OP_UUV:  uuv_ff  <= mul_res;
            rds_pkg::OP_T1:   t1_ff   <= mul_res;
            rds_pkg::OP_T2:   t2_ff   <= mul_res;
            rds_pkg::OP_T3:   t3_ff   <= mul_res;
            rds_pkg::OP_T4:   t4_ff   <= mul_res;
            rds_pkg::OP_EU:   eu_ff   <= mul_res;
            rds_pkg::OP_EV:   ev_ff   <= mul_res;
            default: ;
         endcase
      end
      if (cmd.combine) begin
         rhsu_ff <= rds_pkg::sat_wide(t1_ff + W'(fa_ff) + uuv_ff - t2_ff);
         rhsv_ff <= rds_pkg::sat_wide(t3_ff + t4_ff - uuv_ff);
      end
   end

   // result
   logic [CW-1:0]        ic;
   logic [RW-1:0]        ir;
   logic [CX-1:0]        ic_x;
   logic [RX-1:0]        ir_x;
   logic                 side;
   logic signed [DW-1:0] res_u, res_v;

   assign ic   = cur_c_ff - CW'(2);
   assign ir   = cur_r_ff - RW'(2);
   assign ic_x = CX'(ic);
   assign ir_x = RX'(ir);
   assign side = (mask_ff[0] && ic == '0) || (mask_ff[1] && ic == CW'(COLS - 1)) ||
                 (mask_ff[2] && ir == '0) || (mask_ff[3] && ir == RW'(ROWS - 1));

   always_comb begin
      if (!mode_ff) begin
         res_u = rds_pkg::sat_out(uc + eu_ff);
         res_v = rds_pkg::sat_out(vc + ev_ff);
      end else begin
         res_u = side ? '0 : rds_pkg::sat_out(rhsu_ff);
         res_v = side ? '0 : rds_pkg::sat_out(rhsv_ff);
      end
   end

   logic out_valid_ff, out_valid_in;
   assign out_valid_in = cmd.load_rsp ? 1'b1 : (out_valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (cmd.load_rsp) begin
         out_u    <= res_u;
         out_v    <= res_v;
         out_row  <= ir_x[rds_pkg::POS_W-1:0];
         out_col  <= ic_x[rds_pkg::POS_W-1:0];
         out_last <= (ir == RW'(ROWS - 1)) && (ic == CW'(COLS - 1));
      end
   end

   assign out_valid       = out_valid_ff;
   assign status.interior = (cur_r_ff >= RW'(2)) && (cur_c_ff >= CW'(2));
   assign status.mul_done = mul_done;
   assign status.euler    = !mode_ff;
   assign status.rsp_full = out_valid_ff;

endmodule

// ----- rtl/rds_ctrl.sv -----
// Controller: sequences one point through window update and, for interior points, products, sums and result load.
module rds_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   rsp_ready,
   input  rds_pkg::dp_status_type status,
   output rds_pkg::ctrl_cmd_type  cmd
);

   typedef enum logic [5:0] {
      S_IDLE     = 6'b000001,
      S_SHIFT    = 6'b000010,
      S_MUL_GO   = 6'b000100,
      S_MUL_WAIT = 6'b001000,
      S_COMBINE  = 6'b010000,
      S_FINISH   = 6'b100000
   } state_type;

   state_type       state_ff, state_in;
   rds_pkg::op_type op_ff, op_in;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      cmd           = '0;
      cmd.op        = op_ff;
      req_ready     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = S_SHIFT;
            end
         end
         S_SHIFT: begin
            cmd.shift = 1'b1;
            op_in     = rds_pkg::OP_LAPU;
            state_in  = S_IDLE;
            if (status.interior) state_in = S_MUL_GO;
         end
         S_MUL_GO: begin
            cmd.mul_start = 1'b1;
            state_in      = S_MUL_WAIT;
         end
         S_MUL_WAIT: begin
            if (status.mul_done) begin
               if (op_ff == rds_pkg::OP_T4) begin
                  state_in = S_COMBINE;
               end else if (op_ff == rds_pkg::OP_EV) begin
                  state_in = S_FINISH;
               end else begin
                  op_in    = rds_pkg::op_type'(op_ff + 4'd1);
                  state_in = S_MUL_GO;
               end
            end
         end
         S_COMBINE: begin
            cmd.combine = 1'b1;
            if (status.euler) begin
               op_in    = rds_pkg::OP_EU;
               state_in = S_MUL_GO;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            // hold until the result register is free or being emptied
            if (!status.rsp_full || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff    <= rds_pkg::OP_LAPU;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

endmodule

// ----- rtl/reaction_diffusion_stencil_step_top.sv -----
// A halo point only updates the line store and windows and gives no result; an interior point's
// result is loaded once its products and sums are done, in right-hand-side or Euler mode. A new
// beat is taken only after the previous point is finished, set by the one shared multiplier
// that forms each product from four 30x30 partial products, over 8 (RHS) or 10 (Euler)
// products. A finished result waits in the output register while the next beat is taken.
// Reset (synchronous, active high) restores register defaults and restarts at padded (0,0).
module reaction_diffusion_stencil_step_top #(
   parameter int COLS      = rds_pkg::COLS_DEF,
   parameter int ROWS      = rds_pkg::ROWS_DEF,
   parameter int FRAC_BITS = rds_pkg::FRAC_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   rds_req_if.sink                      req,
   rds_rsp_if.source                    rsp,
   input  logic                         csr_we,
   input  logic [rds_pkg::IDX_W-1:0]    csr_index,
   input  logic [rds_pkg::CSR_W-1:0]    csr_wdata
);

   rds_pkg::ctrl_cmd_type  cmd;
   rds_pkg::dp_status_type status;

   rds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_ready (rsp.ready),
      .status    (status),
      .cmd       (cmd)
   );

   rds_dp #(
      .COLS      (COLS),
      .ROWS      (ROWS),
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .csr_we         (csr_we),
      .csr_index      (rds_pkg::csr_index_type'(csr_index)),
      .csr_wdata      (csr_wdata),
      .in_u           (req.u_value),
      .in_v           (req.v_value),
      .in_frame_start (req.frame_start),
      .out_ready      (rsp.ready),
      .out_valid      (rsp.valid),
      .out_u          (rsp.u_out),
      .out_v          (rsp.v_out),
      .out_row        (rsp.out_row),
      .out_col        (rsp.out_col),
      .out_last       (rsp.frame_last)
   );

`ifndef SYNTH
   // a pending result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!status.rsp_full || rsp.ready))
      else $error("result register overwritten");

   // every taken beat updates the window on the next cycle
   a_take_shift: assert property (@(posedge clock) disable iff (reset)
      cmd.take |=> cmd.shift)
      else $error("beat taken without window update");

   // multiplier completion is a single-cycle pulse
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      status.mul_done |=> !status.mul_done)
      else $error("multiplier done held");

   // no new beat while a product is in flight
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.mul_start |=> !req.ready)
      else $error("beat accepted during product");
`endif

endmodule
